// File: rtl/core/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types, codes and constants of the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    localparam int HELD_SPACE_DEPTH = 32;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] cell_byte;
        logic       row_end;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ONE   = 2'd1,
        ACT_FLUSH = 2'd2
    } t_act;

    typedef struct packed {
        logic accept;
        logic load_pend;
        logic flush_rd;
        logic load_flush;
    } t_cmd;

    typedef struct packed {
        t_act act;
        logic slot_free;
        logic flush_last;
    } t_sts;

endpackage

// File: rtl/core/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Streaming CSV line tokenizer with quoted sections and trailing-space hold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one byte of a line
//   or a line-end marker per transfer. Output channel (o_out_valid /
//   i_out_stall / o_out) carries cell bytes, end-of-cell items and
//   whitespace overflow notices; last marks the final result of an item.
//   An item that yields no result leaves the sequencer idle. An item with
//   one result is kept in a pending register and loaded into the output
//   register once the output slot is free. A byte that releases N held
//   whitespace bytes first reads each from memory and loads it to output.
//   The output register lets the next item in while a result waits.
//   A stalled output holds its item; the sequencer waits on the output slot
//   and raises o_in_stall until the last result of the current item is
//   loaded into the output register.
//   Reset clears quote, lookahead, cell and hold state and empties the
//   output register; the held-space memory needs no clearing.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
    parameter int HELD_SPACE_DEPTH = csvfs_pkg::HELD_SPACE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  csvfs_pkg::t_in_item   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output csvfs_pkg::t_out_item  o_out
);

    csvfs_pkg::t_cmd cmd;
    csvfs_pkg::t_sts sts;

    csvfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    csvfs_dp #(
        .HELD_SPACE_DEPTH (HELD_SPACE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// File: rtl/core/csvfs_ctrl.sv
// ----------------------------------------------------------------------------
// csvfs_ctrl
// Sequencer: accepts items, issues single results and walks held-space flushes.
// ----------------------------------------------------------------------------
module csvfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  csvfs_pkg::t_sts   i_sts,
    output csvfs_pkg::t_cmd   o_cmd,
    output logic              o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_EMIT      = 4'b0010,
        S_FLUSH_RD  = 4'b0100,
        S_FLUSH_OUT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.act)
                        csvfs_pkg::ACT_ONE:   n_state = S_EMIT;
                        csvfs_pkg::ACT_FLUSH: n_state = S_FLUSH_RD;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_pend = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FLUSH_RD: begin
                o_cmd.flush_rd = 1'b1;
                n_state        = S_FLUSH_OUT;
            end
            S_FLUSH_OUT: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_flush = 1'b1;
                    n_state          = i_sts.flush_last ? S_EMIT : S_FLUSH_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: rtl/core/csvfs_dp.sv
// ----------------------------------------------------------------------------
// csvfs_dp
// Datapath: byte decode, cell flags, held-space memory and output register.
// ----------------------------------------------------------------------------
module csvfs_dp #(
    parameter int HELD_SPACE_DEPTH = csvfs_pkg::HELD_SPACE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csvfs_pkg::t_in_item   i_in,
    input  csvfs_pkg::t_cmd       i_cmd,
    input  logic                  i_out_stall,
    output csvfs_pkg::t_sts       o_sts,
    output logic                  o_out_valid,
    output csvfs_pkg::t_out_item  o_out
);

    localparam int CW = $clog2(HELD_SPACE_DEPTH + 1);
    localparam int AW = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;

    logic                 r_qm;
    logic                 r_la;
    logic                 r_has;
    logic [CW-1:0]        r_cnt;
    logic [AW-1:0]        r_idx;
    logic [7:0]           r_rd_data;
    logic [7:0]           r_mem [HELD_SPACE_DEPTH];
    csvfs_pkg::t_out_item r_pend;
    csvfs_pkg::t_out_item r_out;
    logic                 r_out_valid;

    logic                 n_qm;
    logic                 n_la;
    logic                 n_has;
    logic [CW-1:0]        n_cnt;
    csvfs_pkg::t_out_item n_pend;
    csvfs_pkg::t_act      act;
    logic                 wr_en;
    logic                 unq;
    logic                 content;
    logic                 is_ws;
    logic                 is_q;
    logic                 is_cm;
    logic [7:0]           c;
    logic [CW-1:0]        cnt_m1;

    assign c     = i_in.char_byte;
    assign is_q  = (c == csvfs_pkg::CH_QUOTE);
    assign is_cm = (c == csvfs_pkg::CH_COMMA);
    assign is_ws = (c == csvfs_pkg::CH_SPACE) ||
                   ((c >= csvfs_pkg::CH_TAB) && (c <= csvfs_pkg::CH_CR));

    always_comb begin
        n_qm    = r_qm;
        n_la    = r_la;
        n_has   = r_has;
        n_cnt   = r_cnt;
        act     = csvfs_pkg::ACT_NONE;
        wr_en   = 1'b0;
        unq     = 1'b0;
        content = 1'b0;
        n_pend  = '{kind: csvfs_pkg::KIND_BYTE, cell_byte: c, row_end: 1'b0, last: 1'b1};
        if (i_in.line_end) begin
            n_qm   = 1'b0;
            n_la   = 1'b0;
            n_has  = 1'b0;
            n_cnt  = '0;
            act    = csvfs_pkg::ACT_ONE;
            n_pend = '{kind: csvfs_pkg::KIND_END, cell_byte: 8'h00, row_end: 1'b1,
                       last: 1'b1};
        end else if (r_la) begin
            n_la = 1'b0;
            if (is_q) begin
                content = 1'b1;
            end else begin
                n_qm = 1'b0;
                unq  = 1'b1;
            end
        end else if (r_qm) begin
            if (is_q) begin
                n_la = 1'b1;
            end else begin
                content = 1'b1;
            end
        end else begin
            unq = 1'b1;
        end
        if (unq) begin
            if (is_q) begin
                n_qm = 1'b1;
            end else if (is_cm) begin
                n_has  = 1'b0;
                n_cnt  = '0;
                act    = csvfs_pkg::ACT_ONE;
                n_pend = '{kind: csvfs_pkg::KIND_END, cell_byte: 8'h00, row_end: 1'b0,
                           last: 1'b1};
            end else begin
                content = 1'b1;
            end
        end
        if (content) begin
            if (is_ws) begin
                if (r_has) begin
                    if (r_cnt < CW'(HELD_SPACE_DEPTH)) begin
                        wr_en = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        act    = csvfs_pkg::ACT_ONE;
                        n_pend = '{kind: csvfs_pkg::KIND_OVF, cell_byte: 8'h00,
                                   row_end: 1'b0, last: 1'b1};
                    end
                end
            end else begin
                n_has = 1'b1;
                act   = (r_cnt != '0) ? csvfs_pkg::ACT_FLUSH : csvfs_pkg::ACT_ONE;
            end
        end
    end

    assign cnt_m1 = r_cnt - CW'(1);

    assign o_sts.act        = act;
    assign o_sts.slot_free  = !r_out_valid || !i_out_stall;
    assign o_sts.flush_last = (CW'(r_idx) == cnt_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qm  <= 1'b0;
            r_la  <= 1'b0;
            r_has <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_qm  <= n_qm;
            r_la  <= n_la;
            r_has <= n_has;
            r_cnt <= n_cnt;
        end else if (i_cmd.load_flush && o_sts.flush_last) begin
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend <= n_pend;
            r_idx  <= '0;
        end else if (i_cmd.load_flush) begin
            r_idx  <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_mem[r_cnt[AW-1:0]] <= c;
        end
        if (i_cmd.flush_rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_pend || i_cmd.load_flush) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pend) begin
            r_out <= r_pend;
        end else if (i_cmd.load_flush) begin
            r_out <= '{kind: csvfs_pkg::KIND_BYTE, cell_byte: r_rd_data, row_end: 1'b0,
                       last: 1'b0};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/csvfs_checker.sv
// ----------------------------------------------------------------------------
// csvfs_checker
// Port-level checks of the CSV field splitter, bound to the top level.
// ----------------------------------------------------------------------------
module csvfs_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  csvfs_pkg::t_in_item   i_in,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  csvfs_pkg::t_out_item  o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output transfer changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left output valid or input stalled");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind != csvfs_pkg::KIND_BYTE)
            |-> o_out.last && (o_out.cell_byte == 8'h00))
        else $error("end or overflow item without last or with data");

    a_row_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.row_end |-> (o_out.kind == csvfs_pkg::KIND_END))
        else $error("row end flag on a non end-of-cell item");

    a_line_end_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.line_end |=> o_in_stall)
        else $error("line end transfer produced no result cycle");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for csv_field_splitter. A directed table covers the
// byte extremes, quoting, doubled quotes, lookahead at comma and line end,
// whitespace hold, release and overflow. Random lines with random cell shapes
// follow. Each output transfer is checked against the table entry or a local tokenizer model.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PREDICTED       = -1;
    localparam int RANDOM_ITEMS    = 105;
    localparam int IDLE_PCT        = 37;
    localparam int SEND_CALM_LEN   = 60;
    localparam int RECV_CALM_FROM  = 100;
    localparam int RECV_CALM_TO    = 160;
    localparam int PRESSURE_AT     = 70;
    localparam int PRESSURE_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 2 * csvfs_pkg::HELD_SPACE_DEPTH + 20;
    localparam int WATCHDOG_LIMIT  = 1000;

    typedef struct {
        csvfs_pkg::t_in_item  item;
        int                   reps;
        int                   n_want;
        csvfs_pkg::t_out_item want;
    } t_stim_row;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    csvfs_pkg::t_in_item  in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    csvfs_pkg::t_out_item out_item;

    // tokenizer state
    bit         in_quotes;
    bit         quote_pending;
    bit         cell_open;
    logic [7:0] held_ws [csvfs_pkg::HELD_SPACE_DEPTH];
    int         held_n;

    csvfs_pkg::t_out_item step_tokens[$];
    csvfs_pkg::t_out_item token_q[$];
    t_stim_row            dir_table[$];

    int n_sent;
    int n_line_ends;
    int n_got;
    int n_ends;
    int n_ovf;
    int n_errors;
    int calm_from = -1;
    int hold_left;
    bit held_off;
    int idle_cycles;

    csv_field_splitter DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_space(logic [7:0] c);
        return c == csvfs_pkg::CH_SPACE ||
               (c >= csvfs_pkg::CH_TAB && c <= csvfs_pkg::CH_CR);
    endfunction

    function automatic void push_token(logic [1:0] kind, logic [7:0] b, logic row_end);
        csvfs_pkg::t_out_item t;
        t = '{kind: kind, cell_byte: b, row_end: row_end, last: 1'b0};
        step_tokens = {step_tokens, t};
    endfunction

    function automatic void end_cell(logic row_end);
        cell_open = 1'b0;
        held_n = 0;
        push_token(csvfs_pkg::KIND_END, 8'h00, row_end);
    endfunction

    function automatic void data_byte(logic [7:0] c);
        if (is_space(c)) begin
            if (!cell_open) return;
            if (held_n < csvfs_pkg::HELD_SPACE_DEPTH) begin
                held_ws[held_n] = c;
                held_n++;
            end else begin
                push_token(csvfs_pkg::KIND_OVF, 8'h00, 1'b0);
            end
            return;
        end
        for (int i = 0; i < held_n; i++) push_token(csvfs_pkg::KIND_BYTE, held_ws[i], 1'b0);
        held_n = 0;
        cell_open = 1'b1;
        push_token(csvfs_pkg::KIND_BYTE, c, 1'b0);
    endfunction

    function automatic void plain_byte(logic [7:0] c);
        if (c == csvfs_pkg::CH_QUOTE) in_quotes = 1'b1;
        else if (c == csvfs_pkg::CH_COMMA) end_cell(1'b0);
        else data_byte(c);
    endfunction

    function automatic void split_item(csvfs_pkg::t_in_item it);
        step_tokens.delete();
        if (it.line_end) begin
            in_quotes = 1'b0;
            quote_pending = 1'b0;
            end_cell(1'b1);
        end else if (quote_pending) begin
            quote_pending = 1'b0;
            if (it.char_byte == csvfs_pkg::CH_QUOTE) begin
                data_byte(it.char_byte);
            end else begin
                in_quotes = 1'b0;
                plain_byte(it.char_byte);
            end
        end else if (in_quotes) begin
            if (it.char_byte == csvfs_pkg::CH_QUOTE) quote_pending = 1'b1;
            else data_byte(it.char_byte);
        end else begin
            plain_byte(it.char_byte);
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic string show(csvfs_pkg::t_out_item t);
        return $sformatf("kind=%0d byte=%02h row_end=%0b last=%0b",
                         t.kind, t.cell_byte, t.row_end, t.last);
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_token(csvfs_pkg::t_out_item got);
        csvfs_pkg::t_out_item want;
        n_got++;
        if (got.kind == csvfs_pkg::KIND_END) n_ends++;
        if (got.kind == csvfs_pkg::KIND_OVF) n_ovf++;
        if (token_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %s", show(got)));
            return;
        end
        want = token_q.pop_front();
        if (got.kind !== want.kind || got.cell_byte !== want.cell_byte ||
            got.row_end !== want.row_end || got.last !== want.last) begin
            report_mismatch($sformatf("result %0d: got %s, want %s",
                                      n_got, show(got), show(want)));
        end
    endtask

    task automatic send_item(csvfs_pkg::t_in_item it, int n_typed = PREDICTED,
                             csvfs_pkg::t_out_item want = '0);
        bit calm;
        calm = calm_from >= 0 && n_sent >= calm_from && n_sent < calm_from + SEND_CALM_LEN;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
        if (it.line_end) n_line_ends++;
        split_item(it);
        if (n_typed == PREDICTED) begin
            foreach (step_tokens[i]) token_q = {token_q, step_tokens[i]};
        end else if (n_typed == 1) begin
            token_q = {token_q, want};
        end
    endtask

    task automatic send_char(logic [7:0] c);
        send_item('{char_byte: c, line_end: 1'b0});
    endtask

    function automatic void dir_row(logic [7:0] c, logic le, int reps, int n_want,
                                    logic [1:0] kind = csvfs_pkg::KIND_BYTE,
                                    logic [7:0] b = 8'h00, logic re = 1'b0);
        t_stim_row r;
        r.item   = '{char_byte: c, line_end: le};
        r.reps   = reps;
        r.n_want = n_want;
        r.want   = '{kind: kind, cell_byte: b, row_end: re, last: 1'b1};
        dir_table = {dir_table, r};
    endfunction

    function automatic logic [7:0] ws_char();
        return $urandom_range(0, 1) ? csvfs_pkg::CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 5))
            0: return csvfs_pkg::CH_SPACE;
            1: return 8'($urandom_range(0, 255));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic send_random_line();
        int n_fields;
        int shape;
        n_fields = $urandom_range(1, 4);
        for (int k = 0; k < n_fields; k++) begin
            shape = $urandom_range(0, 9);
            repeat ($urandom_range(0, 2)) send_char(ws_char());
            if (shape < 5) begin
                repeat ($urandom_range(1, 6)) send_char(word_char());
            end else if (shape < 8) begin
                send_char(csvfs_pkg::CH_QUOTE);
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 4))
                        0: send_char(csvfs_pkg::CH_COMMA);
                        1: begin
                            send_char(csvfs_pkg::CH_QUOTE);
                            send_char(csvfs_pkg::CH_QUOTE);
                        end
                        default: send_char(word_char());
                    endcase
                end
                if ($urandom_range(0, 7) != 0) send_char(csvfs_pkg::CH_QUOTE);
            end else if (shape == 8) begin
                send_char(8'h61 + 8'($urandom_range(0, 25)));
                repeat ($urandom_range(csvfs_pkg::HELD_SPACE_DEPTH - 4,
                                       csvfs_pkg::HELD_SPACE_DEPTH + 4))
                    send_char(ws_char());
                if ($urandom_range(0, 1)) send_char(8'h61 + 8'($urandom_range(0, 25)));
            end else begin
                repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(0, 2)) send_char(ws_char());
            if (k < n_fields - 1) send_char(csvfs_pkg::CH_COMMA);
        end
        if ($urandom_range(0, 9) != 0)
            send_item('{char_byte: 8'($urandom_range(0, 255)), line_end: 1'b1});
    endtask

    // output side: check, then pick the stall for the next cycle
    always @(posedge clk) begin
        logic next_stall;
        if (rst_n && out_valid && !out_stall) check_token(out_item);
        if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
        end else if (!held_off && n_got >= PRESSURE_AT) begin
            held_off = 1'b1;
            hold_left = PRESSURE_CYCLES - 1;
            next_stall = 1'b1;
        end else if (n_got >= RECV_CALM_FROM && n_got < RECV_CALM_TO) begin
            next_stall = 1'b0;
        end else begin
            next_stall = $urandom_range(0, 99) < IDLE_PCT;
        end
        out_stall <= next_stall;
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        dir_row(8'h00, 1'b1, 1, 1, csvfs_pkg::KIND_END, 8'h00, 1'b1);
        dir_row(8'h00, 1'b0, 1, 1, csvfs_pkg::KIND_BYTE, 8'h00);
        dir_row(8'hFF, 1'b0, 1, 1, csvfs_pkg::KIND_BYTE, 8'hFF);
        dir_row(csvfs_pkg::CH_SPACE, 1'b0, 1, 0);
        dir_row(csvfs_pkg::CH_TAB, 1'b0, 1, 0);
        dir_row(8'h41, 1'b0, 1, PREDICTED);
        dir_row(csvfs_pkg::CH_COMMA, 1'b0, 1, 1, csvfs_pkg::KIND_END, 8'h00, 1'b0);
        dir_row(csvfs_pkg::CH_CR, 1'b0, 1, 0);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 0);
        dir_row(csvfs_pkg::CH_COMMA, 1'b0, 1, 1, csvfs_pkg::KIND_BYTE, csvfs_pkg::CH_COMMA);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 0);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 1, csvfs_pkg::KIND_BYTE, csvfs_pkg::CH_QUOTE);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 0);
        dir_row(8'h08, 1'b0, 1, 1, csvfs_pkg::KIND_BYTE, 8'h08);
        dir_row(8'h0E, 1'b0, 1, 1, csvfs_pkg::KIND_BYTE, 8'h0E);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 0);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 0);
        dir_row(8'h00, 1'b1, 1, 1, csvfs_pkg::KIND_END, 8'h00, 1'b1);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 0);
        dir_row(8'h0A, 1'b0, 1, 0);
        dir_row(8'h78, 1'b0, 1, 1, csvfs_pkg::KIND_BYTE, 8'h78);
        dir_row(8'h0C, 1'b0, 1, 0);
        dir_row(8'hFF, 1'b1, 1, 1, csvfs_pkg::KIND_END, 8'h00, 1'b1);
        dir_row(8'h42, 1'b0, 1, 1, csvfs_pkg::KIND_BYTE, 8'h42);
        dir_row(csvfs_pkg::CH_SPACE, 1'b0, csvfs_pkg::HELD_SPACE_DEPTH, 0);
        dir_row(8'h0B, 1'b0, 2, 1, csvfs_pkg::KIND_OVF, 8'h00);
        dir_row(8'h43, 1'b0, 1, PREDICTED);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 0);
        dir_row(csvfs_pkg::CH_QUOTE, 1'b0, 1, 0);
        dir_row(csvfs_pkg::CH_COMMA, 1'b0, 1, 1, csvfs_pkg::KIND_END, 8'h00, 1'b0);
        dir_row(8'h00, 1'b1, 1, 1, csvfs_pkg::KIND_END, 8'h00, 1'b1);

        foreach (dir_table[r]) begin
            repeat (dir_table[r].reps)
                send_item(dir_table[r].item, dir_table[r].n_want, dir_table[r].want);
        end

        base = n_sent;
        calm_from = base + 40;
        while (n_sent < base + RANDOM_ITEMS) send_random_line();
        in_valid <= 1'b0;

        while (token_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d line ends); checked %0d results,",
                 n_sent, n_line_ends, n_got);
        $display("including %0d cell ends and %0d whitespace overflow notices.",
                 n_ends, n_ovf);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/csvfs_pkg.sv
rtl/core/csvfs_ctrl.sv
rtl/core/csvfs_dp.sv
rtl/core/csv_field_splitter.sv
rtl/core/csvfs_checker.sv
verif/testbench.sv
